@@ src/dsc_pkg.sv @@
// Shared types and constants for the DER signature encoding checker.
`timescale 1ns / 1ps

package dsc_pkg;

  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CNT_W-1:0] COUNT_MAX   = 7'd127;
  localparam logic [CNT_W-1:0] SIG_LEN_MIN = 7'd8;
  localparam logic [CNT_W-1:0] SCHNORR_LEN = 7'd64;

  localparam logic [7:0] TAG_SEQ = 8'h30;
  localparam logic [7:0] TAG_INT = 8'h02;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DER_REQUIRED = 4'd1;

  // check_mode codes (the unused code behaves as generic)
  localparam logic [1:0] MODE_GENERIC = 2'd0;
  localparam logic [1:0] MODE_ECDSA   = 2'd1;
  localparam logic [1:0] MODE_SCHNORR = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_BAD_LENGTH  = 2'd1;
  localparam logic [1:0] STATUS_DER_ERROR   = 2'd2;
  localparam logic [1:0] STATUS_NOT_SCHNORR = 2'd3;

  typedef struct packed {
    logic [7:0] sig_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       is_schnorr;
  } verdict_t;

endpackage

@@ src/dsc_in_if.sv @@
// Input channel: one signature byte per word.
`timescale 1ns / 1ps

interface dsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sig_byte;
  logic       last_byte;

  modport source (output valid, output sig_byte, output last_byte, input ready);
  modport sink   (input valid, input sig_byte, input last_byte, output ready);
endinterface

@@ src/dsc_out_if.sv @@
// Output channel: one verdict word per signature.
`timescale 1ns / 1ps

interface dsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       is_schnorr;

  modport source (output valid, output status, output is_schnorr, input ready);
  modport sink   (input valid, input status, input is_schnorr, output ready);
endinterface

@@ src/dsc_cfg_if.sv @@
// Configuration write channel.
`timescale 1ns / 1ps

interface dsc_cfg_if;
  import dsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/der_signature_encoding_checker_unit.sv @@
// Top level: strict DER / Schnorr length signature encoding checker.
// The verdict word is loaded into the result register when the final byte leaves the input register.
// Throughput: one byte per cycle while no final byte waits for room in the result register;
// set by the single capture/verdict stage between the input register and the result register.
// Reset: synchronous, clears the valid flags of both registers and per-signature state;
// check_mode resets to generic and der_required to 1.
`timescale 1ns / 1ps

module der_signature_encoding_checker_unit #(
  parameter int MAX_SIG_LEN = 72
) (
  input  logic      clk,
  input  logic      rst,
  dsc_in_if.sink    sig_in,
  dsc_out_if.source verdict_out,
  dsc_cfg_if.sink   cfg
);
  import dsc_pkg::*;

  item_t    in_item;
  item_t    item;
  logic     item_valid;
  logic     in_ready;
  logic     advance;
  logic     out_free;
  verdict_t verdict;
  verdict_t verdict_q;

  assign in_item.sig_byte  = sig_in.sig_byte;
  assign in_item.last_byte = sig_in.last_byte;
  assign sig_in.ready      = in_ready;
  assign cfg.ready         = 1'b1;

  // a final byte waits for room in the result register; other bytes always move
  assign advance = item_valid && (!item.last_byte || out_free);

  dsc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (sig_in.valid),
    .in_item    (in_item),
    .in_ready   (in_ready),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  dsc_core #(
    .MAX_SIG_LEN (MAX_SIG_LEN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .advance   (advance),
    .item      (item),
    .verdict   (verdict)
  );

  dsc_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && item.last_byte),
    .verdict_in  (verdict),
    .out_free    (out_free),
    .out_valid   (verdict_out.valid),
    .out_ready   (verdict_out.ready),
    .verdict_out (verdict_q)
  );

  assign verdict_out.status     = verdict_q.status;
  assign verdict_out.is_schnorr = verdict_q.is_schnorr;

endmodule

@@ src/dsc_in_stage.sv @@
// Input register for incoming signature bytes.
`timescale 1ns / 1ps

module dsc_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  dsc_pkg::item_t in_item,
  output logic          in_ready,
  input  logic          advance,
  output logic          item_valid,
  output dsc_pkg::item_t item
);
  import dsc_pkg::*;

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

@@ src/dsc_core.sv @@
// Per-signature field capture, configuration registers and verdict logic.
`timescale 1ns / 1ps

module dsc_core #(
  parameter int MAX_SIG_LEN = 72
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           advance,
  input  dsc_pkg::item_t                 item,
  output dsc_pkg::verdict_t              verdict
);
  import dsc_pkg::*;

  localparam logic [CNT_W-1:0] SIG_LEN_MAX = CNT_W'(MAX_SIG_LEN);

  logic [1:0]       check_mode;
  logic             der_required;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       declared_total, declared_total_next;
  logic [7:0]       r_length, r_length_next;
  logic [7:0]       s_length, s_length_next;
  logic [7:0]       r_lead_byte, r_lead_byte_next;
  logic [7:0]       s_lead_byte, s_lead_byte_next;
  logic [1:0]       pad_flags, pad_flags_next;
  logic             tags_ok, tags_ok_next;

  logic [9:0]       pos;
  logic [9:0]       s0;
  logic [7:0]       b;
  logic [7:0]       size8;
  logic             der_ok;
  logic             is64;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode   <= MODE_GENERIC;
      der_required <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHECK_MODE:   check_mode   <= cfg_data[1:0];
        REG_DER_REQUIRED: der_required <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // capture of the current byte; later positions depend on the stored R length
  always_comb begin
    pos = {3'b000, byte_count};
    s0  = {2'b00, r_length} + 10'd4;
    b   = item.sig_byte;

    byte_count_next     = byte_count;
    declared_total_next = declared_total;
    r_length_next       = r_length;
    s_length_next       = s_length;
    r_lead_byte_next    = r_lead_byte;
    s_lead_byte_next    = s_lead_byte;
    pad_flags_next      = pad_flags;
    tags_ok_next        = tags_ok;

    if (byte_count != COUNT_MAX) begin
      byte_count_next = byte_count + 7'd1;
      if (pos == 10'd0 && b != TAG_SEQ) tags_ok_next = 1'b0;
      if (pos == 10'd1) declared_total_next = b;
      if (pos == 10'd2 && b != TAG_INT) tags_ok_next = 1'b0;
      if (pos == 10'd3) r_length_next = b;
      if (pos == 10'd4) r_lead_byte_next = b;
      if (pos == 10'd5 && r_lead_byte == 8'h00 && !b[7]) pad_flags_next[0] = 1'b1;
      if (pos >= 10'd4) begin
        if (pos == s0 && b != TAG_INT) tags_ok_next = 1'b0;
        if (pos == s0 + 10'd1) s_length_next = b;
        if (pos == s0 + 10'd2) s_lead_byte_next = b;
        if (pos == s0 + 10'd3 && s_lead_byte == 8'h00 && !b[7]) pad_flags_next[1] = 1'b1;
      end
    end
  end

  // strict DER rules on the state including the final byte, and the verdict by check mode
  always_comb begin
    size8  = {1'b0, byte_count_next};
    der_ok = 1'b1;
    if (byte_count_next < SIG_LEN_MIN || byte_count_next > SIG_LEN_MAX) der_ok = 1'b0;
    if (!tags_ok_next) der_ok = 1'b0;
    if (declared_total_next != size8 - 8'd2) der_ok = 1'b0;
    if (r_length_next == 8'd0 || r_lead_byte_next[7]) der_ok = 1'b0;
    if (r_length_next > size8 - 8'd7) der_ok = 1'b0;
    if (r_length_next > 8'd1 && pad_flags_next[0]) der_ok = 1'b0;
    if (s_length_next == 8'd0 || s_lead_byte_next[7]) der_ok = 1'b0;
    if ({2'b00, r_length_next} + {2'b00, s_length_next} + 10'd6 != {2'b00, size8})
      der_ok = 1'b0;
    if (s_length_next > 8'd1 && pad_flags_next[1]) der_ok = 1'b0;

    is64 = (byte_count_next == SCHNORR_LEN);
    verdict.is_schnorr = is64;
    if (check_mode == MODE_SCHNORR) begin
      verdict.status = is64 ? STATUS_OK : STATUS_NOT_SCHNORR;
    end else if (is64) begin
      verdict.status = (check_mode == MODE_ECDSA) ? STATUS_BAD_LENGTH : STATUS_OK;
    end else begin
      verdict.status = (der_required && !der_ok) ? STATUS_DER_ERROR : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      declared_total <= '0;
      r_length       <= '0;
      s_length       <= '0;
      r_lead_byte    <= '0;
      s_lead_byte    <= '0;
      pad_flags      <= '0;
      tags_ok        <= 1'b1;
    end else if (advance) begin
      if (item.last_byte) begin
        byte_count     <= '0;
        declared_total <= '0;
        r_length       <= '0;
        s_length       <= '0;
        r_lead_byte    <= '0;
        s_lead_byte    <= '0;
        pad_flags      <= '0;
        tags_ok        <= 1'b1;
      end else begin
        byte_count     <= byte_count_next;
        declared_total <= declared_total_next;
        r_length       <= r_length_next;
        s_length       <= s_length_next;
        r_lead_byte    <= r_lead_byte_next;
        s_lead_byte    <= s_lead_byte_next;
        pad_flags      <= pad_flags_next;
        tags_ok        <= tags_ok_next;
      end
    end
  end

endmodule

@@ src/dsc_out_stage.sv @@
// Result register holding one verdict word until taken.
`timescale 1ns / 1ps

module dsc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dsc_pkg::verdict_t verdict_in,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output dsc_pkg::verdict_t verdict_out
);
  import dsc_pkg::*;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict_out <= verdict_in;
    end
  end

endmodule
